// ===== hdl/avm7seg_pkg.sv =====
// Shared types and constants for the averaged voltmeter display core.
// Holds the transaction payload structs, conversion constants and the segment table.
// No dependencies.
`default_nettype none

package avm7seg_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned SUM_W    = 13;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned VOLT_W   = 6;
  localparam int unsigned SEG_W    = 7;
  localparam int unsigned DIGIT_W  = 4;

  localparam int unsigned FULL_SCALE_TENTHS = 33;
  localparam int unsigned ROUND_OFFSET      = 511;
  localparam int unsigned ADC_MAX           = 1023;
  localparam int unsigned RADIX             = 10;

  localparam int unsigned RECIP_SHIFT = 33;
  localparam int unsigned PROD_W      = 48;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_REFRESH = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample;
  } meas_item_t;

  typedef struct packed {
    logic [SEG_W-1:0]  segments;
    logic              high_digit_on;
    logic              low_digit_on;
    logic [VOLT_W-1:0] volts_tenths;
  } disp_item_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] pat;
    case (digit)
      4'h0: pat = 7'h3F;
      4'h1: pat = 7'h06;
      4'h2: pat = 7'h5B;
      4'h3: pat = 7'h4F;
      4'h4: pat = 7'h66;
      4'h5: pat = 7'h6D;
      4'h6: pat = 7'h7D;
      4'h7: pat = 7'h07;
      4'h8: pat = 7'h7F;
      4'h9: pat = 7'h6F;
      4'hA: pat = 7'h77;
      4'hB: pat = 7'h7C;
      4'hC: pat = 7'h39;
      4'hD: pat = 7'h5E;
      4'hE: pat = 7'h79;
      default: pat = 7'h71;
    endcase
    return pat;
  endfunction

  function automatic logic [DIGIT_W-1:0] tens_of(input logic [VOLT_W-1:0] v);
    logic [DIGIT_W-1:0] t;
    if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/avm7seg_if.sv =====
// Valid/ready channel interfaces for the averaged voltmeter display core.
// Depends on avm7seg_pkg for the payload structs.
`default_nettype none

interface avm7seg_meas_if
  import avm7seg_pkg::*;
;
  logic       valid;
  logic       ready;
  meas_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface avm7seg_disp_if
  import avm7seg_pkg::*;
;
  logic       valid;
  logic       ready;
  disp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/averaged_voltmeter_seven_segment_core.sv =====
// Averaged voltmeter core driving a two-digit multiplexed seven-segment display.
// Depends on avm7seg_pkg and the channel interfaces in avm7seg_if.sv.
//
// Usage:
//   meas carries one transaction per ADC sample (op = sample) or per display
//   refresh tick (op = refresh). Samples are summed; the sample that closes a
//   group of SAMPLES_PER_AVERAGE converts the sum to tenths of a volt and clears
//   the accumulator. Samples give no output transaction.
//   Each refresh tick gives one disp transaction: the segment pattern of the
//   tens digit on one tick, the units digit on the next, with the matching
//   digit enable and the shown voltage.
//   Throughput is one transaction per cycle while the skid register is empty;
//   a refresh result is registered in the output register before it appears
//   on disp. The conversion is a single constant reciprocal multiply between
//   the input handshake and the state registers. When disp stalls, one more
//   result is held in a skid register and meas drops ready until it drains.
//   Reset clears the sum, the count, the shown voltage (0 until the first
//   conversion) and the digit phase (tens first), and empties the output.
`default_nettype none

module averaged_voltmeter_seven_segment_core
  import avm7seg_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_AVERAGE = 8
) (
  input  wire                 clk,
  input  wire                 rst,
  avm7seg_meas_if.sink        meas,
  avm7seg_disp_if.source      disp
);

  localparam longint unsigned DIVISOR = longint'(ADC_MAX) * longint'(SAMPLES_PER_AVERAGE);
  localparam longint unsigned RECIP   = ((64'd1 << RECIP_SHIFT) + DIVISOR - 64'd1) / DIVISOR;
  localparam logic [PROD_W-1:0] MUL_C = PROD_W'(longint'(FULL_SCALE_TENTHS) * RECIP);
  localparam logic [PROD_W-1:0] ADD_C = PROD_W'(longint'(ROUND_OFFSET) * RECIP);
  localparam logic [COUNT_W:0]  GROUP = (COUNT_W+1)'(SAMPLES_PER_AVERAGE);

  logic [SUM_W-1:0]   sample_sum;
  logic [COUNT_W-1:0] sample_count;
  logic [VOLT_W-1:0]  shown_voltage;
  logic               digit_phase;

  logic               out_valid;
  disp_item_t         out_data;
  logic               skid_valid;
  disp_item_t         skid_data;

  logic               accept;
  logic               is_sample;
  logic               is_refresh;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W:0]   count_inc;
  logic               group_done;
  logic [PROD_W-1:0]  prod;
  logic [VOLT_W-1:0]  volt_next;
  logic [DIGIT_W-1:0] tens;
  logic [DIGIT_W-1:0] units;
  disp_item_t         result;

  assign meas.ready = ~skid_valid;
  assign accept     = meas.valid & ~skid_valid;
  assign is_sample  = accept & (meas.data.op == OP_SAMPLE);
  assign is_refresh = accept & (meas.data.op == OP_REFRESH);

  assign sum_next   = sample_sum + SUM_W'(meas.data.sample);
  assign count_inc  = {1'b0, sample_count} + (COUNT_W+1)'(1);
  assign group_done = (count_inc >= GROUP);
  assign prod       = PROD_W'(sum_next) * MUL_C + ADD_C;
  assign volt_next  = prod[RECIP_SHIFT +: VOLT_W];

  assign tens  = tens_of(shown_voltage);
  assign units = DIGIT_W'(shown_voltage - VOLT_W'(tens) * VOLT_W'(RADIX));

  always_comb begin
    result.volts_tenths = shown_voltage;
    if (!digit_phase) begin
      result.segments      = seg_pattern(tens);
      result.high_digit_on = 1'b1;
      result.low_digit_on  = 1'b0;
    end else begin
      result.segments      = seg_pattern(units);
      result.high_digit_on = 1'b0;
      result.low_digit_on  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      sample_count  <= '0;
      shown_voltage <= '0;
      digit_phase   <= 1'b0;
    end else begin
      if (is_sample) begin
        if (group_done) begin
          sample_sum    <= '0;
          sample_count  <= '0;
          shown_voltage <= volt_next;
        end else begin
          sample_sum   <= sum_next;
          sample_count <= count_inc[COUNT_W-1:0];
        end
      end
      if (is_refresh) begin
        digit_phase <= ~digit_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !disp.ready) begin
      if (is_refresh) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= is_refresh;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !disp.ready) begin
      if (is_refresh) begin
        skid_data <= result;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (is_refresh) begin
      out_data <= result;
    end
  end

  assign disp.valid = out_valid;
  assign disp.data  = out_data;

endmodule

`default_nettype wire

// ===== tb/averaged_voltmeter_seven_segment_core_tb.sv =====
`timescale 1ns / 1ps
// Regression bench for averaged_voltmeter_seven_segment_core: drives sample and refresh
// transactions, predicts every display frame and compares it field by field.
// Depends on avm7seg_pkg and the channel interfaces in avm7seg_if.sv.

module averaged_voltmeter_seven_segment_core_tb;
  import avm7seg_pkg::*;

  localparam int unsigned GROUP_LEN = 8;
  localparam logic [16*7-1:0] GLYPHS = {
    7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
    7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  logic clk;
  logic rst;

  avm7seg_meas_if meas_ch ();
  avm7seg_disp_if disp_ch ();

  averaged_voltmeter_seven_segment_core #(
    .SAMPLES_PER_AVERAGE(GROUP_LEN)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .meas(meas_ch),
    .disp(disp_ch)
  );

  logic [SUM_W-1:0]   acc_sum;
  int unsigned        acc_count;
  logic [VOLT_W-1:0]  shown_tenths;
  logic               units_phase;
  disp_item_t         pending_frames[$];
  int unsigned        mismatches;
  bit                 gaps_on;
  bit                 stall_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("averaged_voltmeter_seven_segment_core regression: fail");
    $finish;
  end

  function automatic void track_meas(input meas_item_t item);
    disp_item_t frame;
    int unsigned digit;
    if (item.op == OP_SAMPLE) begin
      acc_sum = acc_sum + SUM_W'(item.sample);
      acc_count++;
      if (acc_count >= GROUP_LEN) begin
        shown_tenths = VOLT_W'(((int'(acc_sum) * 33 + 511) / 1023) / GROUP_LEN);
        acc_sum = '0;
        acc_count = 0;
      end
    end else begin
      digit = units_phase ? shown_tenths % 10 : shown_tenths / 10;
      frame.segments      = GLYPHS[digit*7 +: 7];
      frame.high_digit_on = !units_phase;
      frame.low_digit_on  = units_phase;
      frame.volts_tenths  = shown_tenths;
      units_phase = !units_phase;
      pending_frames.push_back(frame);
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    disp_item_t want;
    disp_item_t got;
    if (!rst) begin
      if (meas_ch.valid && meas_ch.ready) track_meas(meas_ch.data);
      if (disp_ch.valid && disp_ch.ready) begin
        got = disp_ch.data;
        if (pending_frames.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = pending_frames.pop_front();
          if (got.segments !== want.segments) begin
            $display("%0t: segments expected %h actual %h", $time, want.segments, got.segments);
            mismatches++;
          end
          if (got.high_digit_on !== want.high_digit_on) begin
            $display("%0t: high_digit_on expected %b actual %b", $time,
                     want.high_digit_on, got.high_digit_on);
            mismatches++;
          end
          if (got.low_digit_on !== want.low_digit_on) begin
            $display("%0t: low_digit_on expected %b actual %b", $time,
                     want.low_digit_on, got.low_digit_on);
            mismatches++;
          end
          if (got.volts_tenths !== want.volts_tenths) begin
            $display("%0t: volts_tenths expected %0d actual %0d", $time,
                     want.volts_tenths, got.volts_tenths);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : display_stall
    int unsigned len;
    disp_ch.ready = 1'b0;
    forever begin
      if (!stall_on) begin
        disp_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          disp_ch.ready <= 1'b0;
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        end else begin
          disp_ch.ready <= 1'b1;
          len = $urandom_range(1, 12);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  task automatic send_meas(input op_t op, input logic [SAMPLE_W-1:0] sample);
    meas_item_t item;
    int unsigned gap;
    int unsigned k;
    item.op = op;
    item.sample = sample;
    gap = 0;
    if (gaps_on) begin
      k = $urandom_range(0, 15);
      if (k >= 13) gap = $urandom_range(6, 30);
      else if (k >= 8) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      meas_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    meas_ch.valid <= 1'b1;
    meas_ch.data  <= item;
    do @(posedge clk); while (!meas_ch.ready);
  endtask

  task automatic test_blank_display();
    send_meas(OP_REFRESH, '0);
  endtask

  task automatic test_full_scale();
    repeat (GROUP_LEN) send_meas(OP_SAMPLE, 10'h3FF);
    send_meas(OP_REFRESH, 10'h3FF);
    send_meas(OP_REFRESH, '0);
  endtask

  task automatic test_zero_scale();
    repeat (GROUP_LEN) send_meas(OP_SAMPLE, '0);
    send_meas(OP_REFRESH, 10'h3FF);
    send_meas(OP_REFRESH, 10'h155);
    send_meas(OP_REFRESH, 10'h2AA);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input bit idle_on);
    int unsigned level;
    int unsigned in_group;
    int unsigned k;
    int s;
    gaps_on  = idle_on;
    stall_on = idle_on;
    level    = $urandom_range(0, 1023);
    in_group = 0;
    for (int unsigned n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < 72) begin
        k = $urandom_range(0, 15);
        if (k == 0) s = 0;
        else if (k == 1) s = 1023;
        else if (k < 4) s = int'($urandom_range(0, 1023));
        else s = int'(level) + int'($urandom_range(0, 40)) - 20;
        if (s < 0) s = 0;
        if (s > 1023) s = 1023;
        send_meas(OP_SAMPLE, s[SAMPLE_W-1:0]);
        in_group++;
        if (in_group == GROUP_LEN) begin
          in_group = 0;
          level = $urandom_range(0, 1023);
        end
      end else begin
        send_meas(OP_REFRESH, SAMPLE_W'($urandom));
      end
    end
  endtask

  task automatic drain_frames();
    meas_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    meas_ch.valid = 1'b0;
    meas_ch.data  = '0;
    acc_sum       = '0;
    acc_count     = 0;
    shown_tenths  = '0;
    units_phase   = 1'b0;
    mismatches    = 0;
    gaps_on       = 1'b1;
    stall_on      = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_blank_display();
    test_full_scale();
    test_zero_scale();
    test_random_traffic(600, 1'b1);
    test_random_traffic(400, 1'b0);
    test_random_traffic(600, 1'b1);
    drain_frames();

    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("averaged_voltmeter_seven_segment_core regression: pass");
    end else begin
      $display("averaged_voltmeter_seven_segment_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/avm7seg_pkg.sv
hdl/avm7seg_if.sv
hdl/averaged_voltmeter_seven_segment_core.sv
tb/averaged_voltmeter_seven_segment_core_tb.sv
